@@ design/tbc32_pkg.sv @@
// Shared types, constants and round functions for the toy 32-bit block cipher.
// No dependencies; used by every other design file through scoped names.
package tbc32_pkg;

    localparam logic [3:0] SBOX [16] = '{
        4'd12, 4'd7, 4'd2, 4'd5, 4'd14, 4'd0, 4'd13, 4'd10,
        4'd15, 4'd1, 4'd11, 4'd8, 4'd9, 4'd3, 4'd4, 4'd6
    };

    localparam logic [15:0] RK4_CONST = 16'd5993;
    localparam logic [31:0] PAD_WORD  = 32'h8000_0000;

    // Register map, word index
    localparam logic REG_CIPHER_KEY = 1'b0;

    typedef struct packed {
        logic [15:0] rk1;
        logic [31:0] rk2;
        logic [15:0] rk3;
        logic [15:0] rk4;
    } t_round_keys;

    function automatic t_round_keys key_schedule(input logic [31:0] key);
        t_round_keys rk;
        rk.rk1 = key[15:0];
        rk.rk2 = {key[7:0], key[15:8], key[19:16], key[31:20]};
        rk.rk3 = key[31:16];
        rk.rk4 = key[31:16] ^ key[15:0] ^ RK4_CONST;
        return rk;
    endfunction

    function automatic logic [15:0] sub16(input logic [15:0] v);
        logic [15:0] r;
        for (int i = 0; i < 4; i++) begin
            r[4*i +: 4] = SBOX[v[4*i +: 4]];
        end
        return r;
    endfunction

    function automatic logic [31:0] sub32(input logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 8; i++) begin
            r[4*i +: 4] = SBOX[v[4*i +: 4]];
        end
        return r;
    endfunction

    // bit i moves to (29*i + 12) mod 16
    function automatic logic [15:0] perm16(input logic [15:0] v);
        logic [15:0] r;
        logic [3:0]  dst;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            dst    = 4'(29 * i + 12);
            r[dst] = v[i];
        end
        return r;
    endfunction

    // bit i moves to (29*i + 12) mod 32
    function automatic logic [31:0] perm32(input logic [31:0] v);
        logic [31:0] r;
        logic [4:0]  dst;
        r = '0;
        for (int i = 0; i < 32; i++) begin
            dst    = 5'(29 * i + 12);
            r[dst] = v[i];
        end
        return r;
    endfunction

    function automatic logic [15:0] round_f(input logic [15:0] x, input logic [15:0] k);
        return perm16(sub16(x ^ k));
    endfunction

    function automatic logic [31:0] lai_massey(input logic [31:0] w, input logic [15:0] k);
        logic [15:0] t;
        t = round_f(w[31:16] ^ w[15:0], k);
        return {w[31:16] ^ t, w[15:0] ^ t};
    endfunction

    function automatic logic [31:0] sp_layer(input logic [31:0] w, input logic [31:0] k);
        return perm32(sub32(w ^ k));
    endfunction

    // Feistel round with no half swap: the upper half carries through
    function automatic logic [31:0] feistel(input logic [31:0] w, input logic [15:0] k);
        return {w[31:16], w[15:0] ^ round_f(w[31:16], k)};
    endfunction

endpackage

@@ design/tbc32_apb.sv @@
// Key register behind the APB port; hands the derived round keys to the core.
// Depends on tbc32_pkg.
module tbc32_apb (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output tbc32_pkg::t_round_keys  o_round_keys
);

    logic [31:0] r_key;
    logic        w_sel_key;

    assign w_sel_key = (paddr[2] == tbc32_pkg::REG_CIPHER_KEY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (psel && penable && pwrite && w_sel_key) begin
            r_key <= pwdata;
        end
    end

    assign prdata       = w_sel_key ? r_key : '0;
    assign o_round_keys = tbc32_pkg::key_schedule(r_key);

endmodule

@@ design/tbc32_feed.sv @@
// Input stage: sets the padding marker on a short final word and inserts the
// extra padding block after a full final word. Depends on tbc32_pkg.
module tbc32_feed (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_plain_word,
    input  logic        i_is_last,
    input  logic [2:0]  i_last_bytes,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_word,
    output logic        o_eom
);

    logic        r_valid, n_valid;
    logic        r_extra, n_extra;
    logic [31:0] r_word,  n_word;
    logic        r_eom,   n_eom;
    logic        w_adv;
    logic        w_take;
    logic [31:0] w_marked;

    assign w_adv   = r_valid && i_ready;
    assign o_ready = !r_valid || (i_ready && !r_extra);
    assign w_take  = i_valid && o_ready;

    always_comb begin
        case (i_last_bytes[1:0])
            2'd1:    w_marked = i_plain_word | 32'h0080_0000;
            2'd2:    w_marked = i_plain_word | 32'h0000_8000;
            2'd3:    w_marked = i_plain_word | 32'h0000_0080;
            default: w_marked = i_plain_word;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_extra = r_extra;
        n_word  = r_word;
        n_eom   = r_eom;
        if (w_adv && r_extra) begin
            // full final word has gone; the padding block follows
            n_valid = 1'b1;
            n_extra = 1'b0;
            n_word  = tbc32_pkg::PAD_WORD;
            n_eom   = 1'b1;
        end else if (w_take) begin
            n_valid = 1'b1;
            if (i_is_last && (i_last_bytes[1:0] == 2'd0)) begin
                n_word  = i_plain_word;
                n_eom   = 1'b0;
                n_extra = 1'b1;
            end else begin
                n_word  = i_is_last ? w_marked : i_plain_word;
                n_eom   = i_is_last;
                n_extra = 1'b0;
            end
        end else if (w_adv) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_extra <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_extra <= n_extra;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_eom  <= n_eom;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_eom   = r_eom;

endmodule

@@ design/tbc32_core.sv @@
// Four-stage round pipeline: Lai-Massey, SP layer, two Feistel rounds.
// The last stage is the output register. Depends on tbc32_pkg.
module tbc32_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  tbc32_pkg::t_round_keys  i_round_keys,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [31:0]             i_word,
    input  logic                    i_eom,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [31:0]             o_word,
    output logic                    o_eom
);

    logic        r_v1, r_v2, r_v3, r_v4;
    logic [31:0] r_w1, r_w2, r_w3, r_w4;
    logic        r_e1, r_e2, r_e3, r_e4;
    logic [31:0] n_w1, n_w2, n_w3, n_w4;
    logic        w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    // a stage takes new data when it is empty or its contents move on
    assign w_rdy4 = !r_v4 || i_ready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign n_w1 = tbc32_pkg::lai_massey(i_word, i_round_keys.rk1);
    assign n_w2 = tbc32_pkg::sp_layer(r_w1, i_round_keys.rk2);
    assign n_w3 = tbc32_pkg::feistel(r_w2, i_round_keys.rk3);
    assign n_w4 = tbc32_pkg::feistel(r_w3, i_round_keys.rk4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_w1 <= n_w1;
            r_e1 <= i_eom;
        end
        if (w_rdy2 && r_v1) begin
            r_w2 <= n_w2;
            r_e2 <= r_e1;
        end
        if (w_rdy3 && r_v2) begin
            r_w3 <= n_w3;
            r_e3 <= r_e2;
        end
        if (w_rdy4 && r_v3) begin
            r_w4 <= n_w4;
            r_e4 <= r_e3;
        end
    end

    assign o_ready = w_rdy1;
    assign o_valid = r_v4;
    assign o_word  = r_w4;
    assign o_eom   = r_e4;

endmodule

@@ design/toy_block_cipher_32_encrypt.sv @@
// Top level of the toy 32-bit block cipher, encryption side.
// Depends on tbc32_pkg, tbc32_apb, tbc32_feed and tbc32_core.
//
//   channel   handshake            payload
//   input     i_valid / o_ready    i_plain_word, i_is_last, i_last_bytes
//   output    o_valid / i_ready    o_cipher_word, o_end_of_message
//   config    APB psel/penable     paddr, pwdata, prdata (cipher_key at 0x0)
//
// One item per cycle while i_ready does not stall; a full final word blocks the
// input while the feed stage emits the padding block after it. Latency is five
// register stages: the feed register, then the four core stages up to o_valid.
// Synchronous active-low reset empties every stage and clears the key.
// A stall on i_ready backs up stage by stage; each stage holds its item.
module toy_block_cipher_32_encrypt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_plain_word,
    input  logic        i_is_last,
    input  logic [2:0]  i_last_bytes,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_cipher_word,
    output logic        o_end_of_message
);

    tbc32_pkg::t_round_keys w_round_keys;
    logic                   w_feed_valid;
    logic                   w_core_ready;
    logic [31:0]            w_feed_word;
    logic                   w_feed_eom;

    assign pready = 1'b1;

    tbc32_apb u_apb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .o_round_keys (w_round_keys)
    );

    tbc32_feed u_feed (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_plain_word (i_plain_word),
        .i_is_last    (i_is_last),
        .i_last_bytes (i_last_bytes),
        .o_valid      (w_feed_valid),
        .i_ready      (w_core_ready),
        .o_word       (w_feed_word),
        .o_eom        (w_feed_eom)
    );

    tbc32_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_round_keys (w_round_keys),
        .i_valid      (w_feed_valid),
        .o_ready      (w_core_ready),
        .i_word       (w_feed_word),
        .i_eom        (w_feed_eom),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_word       (o_cipher_word),
        .o_eom        (o_end_of_message)
    );

    // a full final word blocks the next item while the padding block is pending
    a_pad_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_is_last && (i_last_bytes[1:0] == 2'd0)) |=> !o_ready)
        else $error("input accepted while padding block pending");

    // once the full final word moves on, the padding block follows and closes the message
    a_pad_is_eom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_feed_valid && w_core_ready && u_feed.r_extra)
        |=> (w_feed_valid && w_feed_eom && (w_feed_word == tbc32_pkg::PAD_WORD)))
        else $error("padding block lost its end-of-message flag");

    // an item held in the feed stage is not dropped or altered by a core stall
    a_feed_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_feed_valid && !w_core_ready) |=> (w_feed_valid && $stable(w_feed_word)
                                            && $stable(w_feed_eom)))
        else $error("feed stage item changed under stall");

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

endmodule
